[hdl/hmsi_pkg.sv]
// Shared types, widths and reset constants of the Hermite motion sample interpolator.
`default_nettype none

package hmsi_pkg;

    // Fixed-point format and field widths
    localparam int FRAC      = 16;
    localparam int ONE_Q     = 1 << FRAC;
    localparam int COORD_W   = 32;
    localparam int COUNT_W   = 7;
    localparam int SHUT_W    = 18;
    localparam int PERIOD_W  = 17;
    localparam int NUM_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    // Derived datapath widths
    localparam int TAN_W  = COORD_W + PERIOD_W + 1 - FRAC;  // floor(vel * period)
    localparam int STEP_W = SHUT_W;                          // positive close - open
    localparam int T_W    = SHUT_W + 2;                      // running sample time
    localparam int S_W    = SHUT_W;                          // segment parameter
    localparam int SQ_W   = 2 * S_W - FRAC;                  // floor(s*s)
    localparam int CU_W   = SQ_W + S_W - FRAC;               // floor(s2*s)
    localparam int H_W    = CU_W + 2;                        // basis weights
    localparam int M_W    = H_W + TAN_W - FRAC;              // one weighted term
    localparam int ACC_W  = M_W + 2;                         // sum of four terms

    // Register reset values
    localparam int MAX_SAMPLES_DEF = 64;
    localparam logic [COUNT_W-1:0]         COUNT_RST  = 7'd32;
    localparam logic signed [SHUT_W-1:0]   OPEN_RST   = -18'sd16384;
    localparam logic signed [SHUT_W-1:0]   CLOSE_RST  = 18'sd16384;
    localparam logic [PERIOD_W-1:0]        PERIOD_RST = 17'd2731;
    localparam int STEP_RST_INT =
        (int'(CLOSE_RST) - int'(OPEN_RST)) / int'(COUNT_RST);
    localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(STEP_RST_INT);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT  = 3'd0,
        CFG_SHUTTER_OPEN  = 3'd1,
        CFG_SHUTTER_CLOSE = 3'd2,
        CFG_FRAME_PERIOD  = 3'd3
    } cfg_idx_t;

    // Sample sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TAN,
        SEQ_RUN
    } seq_state_t;

    // Input beat: one axis of one vertex over three frames
    typedef struct packed {
        logic signed [COORD_W-1:0] prev_pos;
        logic signed [COORD_W-1:0] prev_vel;
        logic signed [COORD_W-1:0] cur_pos;
        logic signed [COORD_W-1:0] cur_vel;
        logic signed [COORD_W-1:0] next_pos;
        logic signed [COORD_W-1:0] next_vel;
    } hmsi_in_t;

    // Result beat
    typedef struct packed {
        logic signed [COORD_W-1:0] position;
        logic [NUM_W-1:0]          sample_number;
        logic                      last;
        logic                      status;
    } hmsi_out_t;

    // One issued sample, sequencer to evaluation pipeline
    typedef struct packed {
        logic signed [S_W-1:0]     s;
        logic signed [COORD_W-1:0] p1;
        logic signed [TAN_W-1:0]   t1;
        logic signed [COORD_W-1:0] p2;
        logic signed [TAN_W-1:0]   t2;
        logic [NUM_W-1:0]          num;
        logic                      last;
        logic                      status;
    } hmsi_issue_t;

endpackage

`default_nettype wire

[hdl/hmsi_div.sv]
// Bit-serial divider that derives the sample time step from the shutter registers.
`default_nettype none

module hmsi_div
    import hmsi_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [SHUT_W-1:0] shutter_open,
    input  wire logic signed [SHUT_W-1:0] shutter_close,
    input  wire logic [COUNT_W-1:0]       count,
    output logic                          busy,
    output logic [STEP_W-1:0]             step
);

    localparam int CNT_W = $clog2(STEP_W);

    logic signed [SHUT_W:0] diff;
    logic                   no_step;
    logic [COUNT_W:0]       trial;
    logic                   ge;
    logic [COUNT_W:0]       trial_sub;

    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COUNT_W-1:0]     rem_reg;
    logic [COUNT_W-1:0]     den_reg;
    logic [STEP_W-1:0]      quo_reg;
    logic [STEP_W-1:0]      step_reg;

    // Operand check: empty or reversed shutter, or zero count, gives a zero step
    assign diff    = SHUT_W'(shutter_close) - SHUT_W'(shutter_open) + (SHUT_W+1)'(0);
    assign no_step = (count == '0) || diff[SHUT_W] || (diff == '0);

    // One quotient bit per cycle, restoring
    assign trial     = {rem_reg, quo_reg[STEP_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            step_reg <= STEP_RST;
        end
        else if (start)
        begin
            if (no_step)
            begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end
            else
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEP_W - 1);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                step_reg <= {quo_reg[STEP_W-2:0], ge};
            end
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= count;
            quo_reg <= diff[STEP_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_reg <= {quo_reg[STEP_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign step = step_reg;

endmodule

`default_nettype wire

[hdl/hmsi_seq.sv]
// Item holding, tangent stage and motion sample sequencer.
`default_nettype none

module hmsi_seq
    import hmsi_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire hmsi_in_t                 item,
    input  wire logic                     div_busy,
    input  wire logic [COUNT_W-1:0]       n_eff,
    input  wire logic [STEP_W-1:0]        step,
    input  wire logic signed [SHUT_W-1:0] shutter_open,
    input  wire logic [PERIOD_W-1:0]      frame_period,
    input  wire logic                     adv,
    output logic                          issue_valid,
    output hmsi_issue_t                   issue
);

    localparam int TP_W = COORD_W + PERIOD_W + 1;

    seq_state_t state_reg, state_next;

    logic accept;
    logic issue_en;
    logic single;
    logic empty;
    logic final_beat;
    logic t_neg;
    logic signed [T_W-1:0] s_sel;

    logic signed [COORD_W-1:0] pos_reg [3];
    logic signed [COORD_W-1:0] vel_reg [3];
    logic signed [TAN_W-1:0]   tan_reg [3];
    logic signed [TP_W-1:0]    tan_prod [3];

    logic signed [T_W-1:0] t_reg;
    logic [NUM_W-1:0]      k_reg;
    logic                  issue_valid_reg;
    hmsi_issue_t           issue_reg, issue_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: if (accept) state_next = SEQ_TAN;
            SEQ_TAN:  state_next = SEQ_RUN;
            SEQ_RUN:  if (issue_en && final_beat) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        item_ready = 1'b0;
        issue_en   = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: item_ready = !div_busy;
            SEQ_TAN:  ;
            SEQ_RUN:  issue_en = adv;
            default:  ;
        endcase
    end

    assign accept = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the three frames of the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0] <= item.prev_pos;
            vel_reg[0] <= item.prev_vel;
            pos_reg[1] <= item.cur_pos;
            vel_reg[1] <= item.cur_vel;
            pos_reg[2] <= item.next_pos;
            vel_reg[2] <= item.next_vel;
        end
    end

    // Tangents: velocity scaled by the frame period
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            tan_prod[i] = $signed({1'b0, frame_period}) * vel_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SEQ_TAN)
        begin
            for (int i = 0; i < 3; i++)
                tan_reg[i] <= tan_prod[i][TP_W-1:FRAC];
        end
    end

    // Sample time walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg <= '0;
            k_reg <= '0;
        end
        else if (state_reg == SEQ_TAN)
        begin
            t_reg <= T_W'(shutter_open);
            k_reg <= '0;
        end
        else if (issue_en)
        begin
            t_reg <= t_reg + T_W'($signed({1'b0, step}));
            k_reg <= k_reg + 1'b1;
        end
    end

    // Mode and segment selection
    assign single     = (n_eff == COUNT_W'(1));
    assign empty      = (n_eff == '0) || (!single && (step == '0));
    assign final_beat = single || empty || (({1'b0, k_reg} + COUNT_W'(1)) == n_eff);
    assign t_neg      = t_reg[T_W-1];
    assign s_sel      = t_neg ? (t_reg + T_W'(ONE_Q)) : t_reg;

    always_comb
    begin
        issue_next.last   = final_beat;
        issue_next.status = empty && !single;
        if (single || empty)
        begin
            // s = 0 reduces the cubic to p1
            issue_next.s   = '0;
            issue_next.p1  = single ? pos_reg[1] : '0;
            issue_next.t1  = '0;
            issue_next.p2  = '0;
            issue_next.t2  = '0;
            issue_next.num = '0;
        end
        else
        begin
            issue_next.s   = s_sel[S_W-1:0];
            issue_next.num = k_reg;
            if (t_neg)
            begin
                issue_next.p1 = pos_reg[0];
                issue_next.t1 = tan_reg[0];
                issue_next.p2 = pos_reg[1];
                issue_next.t2 = tan_reg[1];
            end
            else
            begin
                issue_next.p1 = pos_reg[1];
                issue_next.t1 = tan_reg[1];
                issue_next.p2 = pos_reg[2];
                issue_next.t2 = tan_reg[2];
            end
        end
    end

    // Issue stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            issue_valid_reg <= 1'b0;
        else if (adv)
            issue_valid_reg <= issue_en;
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
            issue_reg <= issue_next;
    end

    assign issue_valid = issue_valid_reg;
    assign issue       = issue_reg;

endmodule

`default_nettype wire

[hdl/hmsi_pipe.sv]
// Hermite evaluation pipeline: powers of s, basis weights, weighted terms, sum and clamp.
`default_nettype none

module hmsi_pipe
    import hmsi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        issue_valid,
    input  wire hmsi_issue_t issue,
    output logic             adv,
    output logic             result_valid,
    input  wire logic        result_ready,
    output hmsi_out_t        result
);

    localparam int SQP_W = 2 * S_W;
    localparam int CUP_W = SQ_W + S_W;
    localparam int MP_W  = H_W + TAN_W;

    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    hmsi_issue_t st2_reg, st3_reg, st4_reg;
    logic signed [SQ_W-1:0] st2_sq_reg, st3_sq_reg;
    logic signed [CU_W-1:0] st3_cu_reg;
    logic signed [H_W-1:0]  h_reg [4];

    logic signed [M_W-1:0]  m_reg [4];
    logic [NUM_W-1:0]       st5_num_reg;
    logic                   st5_last_reg;
    logic                   st5_status_reg;
    hmsi_out_t              result_reg;

    logic signed [SQP_W-1:0] sq_prod;
    logic signed [CUP_W-1:0] cu_prod;
    logic signed [H_W-1:0]   e_s, e_s2, e_s3;
    logic signed [H_W-1:0]   h_next [4];
    logic signed [TAN_W-1:0] x_op [4];
    logic signed [MP_W-1:0]  m_prod [4];
    logic signed [ACC_W-1:0] sum;
    logic signed [COORD_W-1:0] sat;

    // Whole pipeline moves when the output register is free or being taken
    assign adv = !v6_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= issue_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 2: s squared
    assign sq_prod = issue.s * issue.s;

    // Stage 3: s cubed
    assign cu_prod = st2_sq_reg * st2_reg.s;

    // Stage 4: basis weights
    assign e_s  = H_W'(st3_reg.s);
    assign e_s2 = H_W'(st3_sq_reg);
    assign e_s3 = H_W'(st3_cu_reg);

    always_comb
    begin
        h_next[0] = (e_s3 <<< 1) - (e_s2 + (e_s2 <<< 1)) + H_W'(ONE_Q);
        h_next[1] = (e_s2 + (e_s2 <<< 1)) - (e_s3 <<< 1);
        h_next[2] = e_s3 - (e_s2 <<< 1) + e_s;
        h_next[3] = e_s3 - e_s2;
    end

    // Stage 5: weighted terms
    assign x_op[0] = TAN_W'(st4_reg.p1);
    assign x_op[1] = TAN_W'(st4_reg.p2);
    assign x_op[2] = st4_reg.t1;
    assign x_op[3] = st4_reg.t2;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            m_prod[i] = h_reg[i] * x_op[i];
    end

    // Stage 6: sum and clamp to the coordinate range
    assign sum = ACC_W'(m_reg[0]) + ACC_W'(m_reg[1]) + ACC_W'(m_reg[2]) + ACC_W'(m_reg[3]);

    always_comb
    begin
        if (sum[ACC_W-1:COORD_W-1] == '0 || sum[ACC_W-1:COORD_W-1] == '1)
            sat = sum[COORD_W-1:0];
        else if (sum[ACC_W-1])
            sat = {1'b1, {(COORD_W-1){1'b0}}};
        else
            sat = {1'b0, {(COORD_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st2_reg    <= issue;
            st2_sq_reg <= sq_prod[SQP_W-1:FRAC];

            st3_reg    <= st2_reg;
            st3_sq_reg <= st2_sq_reg;
            st3_cu_reg <= cu_prod[CUP_W-1:FRAC];

            st4_reg    <= st3_reg;
            for (int i = 0; i < 4; i++)
                h_reg[i] <= h_next[i];

            for (int i = 0; i < 4; i++)
                m_reg[i] <= m_prod[i][MP_W-1:FRAC];
            st5_num_reg    <= st4_reg.num;
            st5_last_reg   <= st4_reg.last;
            st5_status_reg <= st4_reg.status;

            result_reg.position      <= sat;
            result_reg.sample_number <= st5_num_reg;
            result_reg.last          <= st5_last_reg;
            result_reg.status        <= st5_status_reg;
        end
    end

    assign result_valid = v6_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[hdl/hermite_motion_sample_interpolator.sv]
// Top level of the Hermite motion sample interpolator: registers, step divider, sequencer, pipeline.
`default_nettype none

// Each beat on the item channel is one axis of one vertex over the previous,
// current and next frames. The block answers with one result beat per motion
// sample (sample_count beats, clamped to MAX_SAMPLES), in increasing time
// order, with last set on the final one; a count of one returns the current
// position; an empty shutter or zero count returns a single beat, status set.
// Items are taken one at a time: an item occupies the sequencer while it is
// latched, while its tangents are formed and while its samples are issued.
// Each sample then runs through a six-stage evaluation pipeline; output
// stalls freeze the pipeline and the sequencer together. A write to a known
// register index starts the time step divider, which produces one quotient
// bit per cycle; items are refused until the divider has finished after the
// last such write.

module hermite_motion_sample_interpolator
    import hmsi_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire hmsi_in_t              item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output hmsi_out_t                  result,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COUNT_W-1:0]       count_reg;
    logic signed [SHUT_W-1:0] open_reg;
    logic signed [SHUT_W-1:0] close_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic                     start_reg;

    logic                     cfg_hit;
    logic [COUNT_W-1:0]       n_eff;
    logic                     div_busy;
    logic [STEP_W-1:0]        step;
    logic                     adv;
    logic                     issue_valid;
    hmsi_issue_t              issue;

    // Register index decode
    always_comb
    begin
        unique case (cfg_index)
            CFG_SAMPLE_COUNT,
            CFG_SHUTTER_OPEN,
            CFG_SHUTTER_CLOSE,
            CFG_FRAME_PERIOD: cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    // Configuration registers; any accepted write restarts the step divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RST;
            open_reg   <= OPEN_RST;
            close_reg  <= CLOSE_RST;
            period_reg <= PERIOD_RST;
            start_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_wr_en && cfg_hit;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_SHUTTER_OPEN:  open_reg   <= cfg_data[SHUT_W-1:0];
                    CFG_SHUTTER_CLOSE: close_reg  <= cfg_data[SHUT_W-1:0];
                    CFG_FRAME_PERIOD:  period_reg <= cfg_data[PERIOD_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Count clamped to the pipeline's sample limit
    assign n_eff = (count_reg > COUNT_W'(MAX_SAMPLES)) ? COUNT_W'(MAX_SAMPLES) : count_reg;

    hmsi_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_reg),
        .shutter_open  (open_reg),
        .shutter_close (close_reg),
        .count         (n_eff),
        .busy          (div_busy),
        .step          (step)
    );

    hmsi_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .div_busy     (div_busy || start_reg),
        .n_eff        (n_eff),
        .step         (step),
        .shutter_open (open_reg),
        .frame_period (period_reg),
        .adv          (adv),
        .issue_valid  (issue_valid),
        .issue        (issue)
    );

    hmsi_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .adv          (adv),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
